FILE: design/mlhc_pkg.sv
// Types and codes shared by the max-line hull container.
`timescale 1ns / 1ps

package mlhc_pkg;

  localparam int SLOPE_W     = 32;
  localparam int ICPT_W      = 48;
  localparam int POINT_W     = 32;
  localparam int VALUE_W     = 64;
  localparam int HELD_W      = 7;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 80;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [ICPT_W-1:0]  b;
    logic signed [SLOPE_W-1:0] m;
  } line_t;

  typedef enum logic [27:0] {
    S_IDLE     = 28'h0000001,
    S_Q_RD     = 28'h0000002,
    S_Q_LD     = 28'h0000004,
    S_Q_ACC    = 28'h0000008,
    S_I_SCAN   = 28'h0000010,
    S_I_SCMP   = 28'h0000020,
    S_P_START  = 28'h0000040,
    S_P_SIMPLE = 28'h0000080,
    S_P_LATX   = 28'h0000100,
    S_P_LATZ   = 28'h0000200,
    S_U_START  = 28'h0000400,
    S_U_LATY   = 28'h0000800,
    S_U_LATZ   = 28'h0001000,
    S_D_START  = 28'h0002000,
    S_D_LATY   = 28'h0004000,
    S_D_LATX   = 28'h0008000,
    S_CR0      = 28'h0010000,
    S_CR1      = 28'h0020000,
    S_CR2      = 28'h0040000,
    S_MUL0     = 28'h0080000,
    S_MUL1     = 28'h0100000,
    S_MUL2     = 28'h0200000,
    S_EVAL     = 28'h0400000,
    S_CP_START = 28'h0800000,
    S_C_RD     = 28'h1000000,
    S_C_WR     = 28'h2000000,
    S_W_NEW    = 28'h4000000,
    S_DONE     = 28'h8000000
  } state_t;

  typedef enum logic [2:0] {
    PH_NEW = 3'b001,
    PH_UP  = 3'b010,
    PH_DN  = 3'b100
  } phase_t;

endpackage

FILE: design/max_line_hull_container.sv
// Upper envelope of lines with insert and maximum-query, sequenced over one multiplier.
`timescale 1ns / 1ps

// Holds up to CAPACITY lines y = slope*x + intercept sorted by slope in a memory with one
// read and one write port and keeps only those on the upper envelope. One item is worked
// at a time and s_tready is high only between items. A query reads each line, multiplies
// it in two partial products on the shared 25x33 multiplier and accumulates it. An insert
// scans lines to find its slot, runs redundancy tests (two exact 82-bit cross products on
// the same multiplier) and moves lines when the table is compacted, plus setup steps.
// The result stays in an output register, so the next item may enter while it waits.
module max_line_hull_container #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // line_slope[31:0], line_intercept[79:32], query_point[111:80]
  input  logic [mlhc_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type[0]
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // best_value[63:0], status[65:64], lines_held[72:66], zero[79:73]
  output logic [mlhc_pkg::OUT_DATA_W-1:0]     m_tdata
);

  import mlhc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  line_t             mem [CAPACITY];
  line_t             rd_q;
  logic [CW-1:0]     addr_w;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [CW-1:0]     waddr_w;
  line_t             wdata;

  state_t            state;
  state_t            ret;
  phase_t            ph;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     k;
  logic [CW-1:0]     p;
  logic [CW-1:0]     jj;
  logic [CW-1:0]     dn;
  logic [CW-1:0]     src;
  logic              up;
  logic              red;
  logic signed [SLOPE_W-1:0] nm;
  logic signed [ICPT_W-1:0]  nb;
  logic signed [POINT_W-1:0] qx;
  logic signed [ICPT_W-1:0]  tb;
  line_t             lx;
  line_t             ly;
  line_t             lz;
  logic [1:0]        st;
  logic signed [VALUE_W-1:0] best;
  logic signed [VALUE_W-1:0] val;
  logic signed [48:0] op_a;
  logic signed [32:0] op_b;
  logic signed [24:0] mul_a;
  logic signed [57:0] prod;
  logic signed [81:0] acc;
  logic signed [81:0] lsave;
  logic              simple_red;

  assign s_tready = (state == S_IDLE);
  assign rd_addr  = addr_w[AW-1:0];
  assign mul_a    = (state == S_MUL0) ? $signed({1'b0, op_a[23:0]}) : op_a[48:24];
  assign val      = acc[63:0] + {{(VALUE_W-ICPT_W){tb[ICPT_W-1]}}, tb};
  assign simple_red = (rd_q.m == nm) && (nb <= rd_q.b);

  always_comb begin
    addr_w  = '0;
    we      = 1'b0;
    waddr_w = '0;
    wdata   = rd_q;
    unique case (state)
      S_Q_RD:    addr_w = k;
      S_I_SCAN:  addr_w = k;
      S_P_START: addr_w = (p == '0) ? '0 : p - CW'(1);
      S_P_LATX:  addr_w = p;
      S_U_START: addr_w = jj;
      S_U_LATY:  addr_w = jj + CW'(1);
      S_D_START: addr_w = dn - CW'(1);
      S_D_LATY:  addr_w = dn - CW'(2);
      S_C_RD:    addr_w = up ? src - CW'(1) : src;
      S_C_WR: begin
        we      = 1'b1;
        waddr_w = up ? src : src - jj + dn + CW'(1);
      end
      S_W_NEW: begin
        we      = 1'b1;
        waddr_w = dn;
        wdata   = '{b: nb, m: nm};
      end
      default: addr_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr_w[AW-1:0]] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      ph       <= PH_NEW;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            nm   <= s_tdata[31:0];
            nb   <= s_tdata[79:32];
            qx   <= s_tdata[111:80];
            k    <= '0;
            best <= '0;
            st   <= ST_OK;
            if (s_tuser[0] == REQ_QUERY) begin
              if (cnt == '0) begin
                st    <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                state <= S_Q_RD;
              end
            end else if (cnt == CW'(CAPACITY)) begin
              st    <= ST_FULL;
              state <= S_DONE;
            end else begin
              state <= S_I_SCAN;
            end
          end
        end
        S_Q_RD: state <= S_Q_LD;
        S_Q_LD: begin
          op_a  <= {{17{rd_q.m[SLOPE_W-1]}}, rd_q.m};
          op_b  <= {qx[POINT_W-1], qx};
          tb    <= rd_q.b;
          ret   <= S_Q_ACC;
          state <= S_MUL0;
        end
        S_Q_ACC: begin
          if ((k == '0) || (val > best)) begin
            best <= val;
          end
          k <= k + CW'(1);
          state <= (k + CW'(1) == cnt) ? S_DONE : S_Q_RD;
        end
        S_I_SCAN: begin
          if (k == cnt) begin
            p     <= k;
            state <= S_P_START;
          end else begin
            state <= S_I_SCMP;
          end
        end
        S_I_SCMP: begin
          if (rd_q.m <= nm) begin
            k     <= k + CW'(1);
            state <= S_I_SCAN;
          end else begin
            p     <= k;
            state <= S_P_START;
          end
        end
        S_P_START: begin
          ph <= PH_NEW;
          if (p == '0 && cnt == '0) begin
            red   <= 1'b0;
            state <= S_EVAL;
          end else if (p == '0 || p == cnt) begin
            state <= S_P_SIMPLE;
          end else begin
            state <= S_P_LATX;
          end
        end
        S_P_SIMPLE: begin
          red   <= simple_red;
          state <= S_EVAL;
        end
        S_P_LATX: begin
          lx    <= rd_q;
          state <= S_P_LATZ;
        end
        S_P_LATZ: begin
          lz    <= rd_q;
          ly    <= '{b: nb, m: nm};
          state <= S_CR0;
        end
        S_U_START: begin
          if (jj == cnt) begin
            dn    <= p;
            ph    <= PH_DN;
            state <= S_D_START;
          end else begin
            state <= S_U_LATY;
          end
        end
        S_U_LATY: begin
          ly <= rd_q;
          if (jj + CW'(1) == cnt) begin
            red   <= (rd_q.m == nm) && (rd_q.b <= nb);
            state <= S_EVAL;
          end else begin
            state <= S_U_LATZ;
          end
        end
        S_U_LATZ: begin
          lz    <= rd_q;
          lx    <= '{b: nb, m: nm};
          state <= S_CR0;
        end
        S_D_START: state <= (dn == '0) ? S_CP_START : S_D_LATY;
        S_D_LATY: begin
          ly <= rd_q;
          if (dn == CW'(1)) begin
            red   <= (rd_q.m == nm) && (rd_q.b <= nb);
            state <= S_EVAL;
          end else begin
            state <= S_D_LATX;
          end
        end
        S_D_LATX: begin
          lx    <= rd_q;
          lz    <= '{b: nb, m: nm};
          state <= S_CR0;
        end
        S_CR0: begin
          op_a  <= {lx.b[ICPT_W-1], lx.b} - {ly.b[ICPT_W-1], ly.b};
          op_b  <= {lz.m[SLOPE_W-1], lz.m} - {ly.m[SLOPE_W-1], ly.m};
          ret   <= S_CR1;
          state <= S_MUL0;
        end
        S_CR1: begin
          lsave <= acc;
          op_a  <= {ly.b[ICPT_W-1], ly.b} - {lz.b[ICPT_W-1], lz.b};
          op_b  <= {ly.m[SLOPE_W-1], ly.m} - {lx.m[SLOPE_W-1], lx.m};
          ret   <= S_CR2;
          state <= S_MUL0;
        end
        S_CR2: begin
          red   <= (lsave >= acc);
          state <= S_EVAL;
        end
        S_MUL0: begin
          prod  <= mul_a * op_b;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= {{24{prod[57]}}, prod};
          prod  <= mul_a * op_b;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + {prod, 24'd0};
          state <= ret;
        end
        S_EVAL: begin
          unique case (ph)
            PH_NEW: begin
              if (red) begin
                state <= S_DONE;
              end else begin
                jj    <= p;
                ph    <= PH_UP;
                state <= S_U_START;
              end
            end
            PH_UP: begin
              if (red) begin
                jj    <= jj + CW'(1);
                state <= S_U_START;
              end else begin
                dn    <= p;
                ph    <= PH_DN;
                state <= S_D_START;
              end
            end
            PH_DN: begin
              if (red) begin
                dn    <= dn - CW'(1);
                state <= S_D_START;
              end else begin
                state <= S_CP_START;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_CP_START: begin
          up    <= (dn == jj);
          src   <= (dn == jj) ? cnt : jj;
          state <= S_C_RD;
        end
        S_C_RD: begin
          if (up ? (src == jj) : (src == cnt)) begin
            state <= S_W_NEW;
          end else begin
            state <= S_C_WR;
          end
        end
        S_C_WR: begin
          src   <= up ? src - CW'(1) : src + CW'(1);
          state <= S_C_RD;
        end
        S_W_NEW: begin
          cnt   <= dn + CW'(1) + cnt - jj;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, HELD_W'(cnt), st, best};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
